// ----- rtl/core/gbts_pkg.sv -----
package gbts_pkg;

    localparam int GBTS_CAPACITY = 1024;

    localparam int OP_W   = 2;
    localparam int POS_W  = 11;
    localparam int CHAR_W = 16;
    localparam int ST_W   = 2;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 32;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OP_W-1:0] OP_READ   = 2'd2;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

    localparam logic [ST_W-1:0] ST_DONE    = 2'd0;
    localparam logic [ST_W-1:0] ST_IGNORED = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL    = 2'd2;

endpackage

// ----- rtl/core/gbts_mem.sv -----
module gbts_mem
    import gbts_pkg::*;
#(
    parameter int CAPACITY = GBTS_CAPACITY
) (
    input  logic                        aclk,
    input  logic                        rd_en,
    input  logic [$clog2(CAPACITY)-1:0] rd_addr,
    output logic [CHAR_W-1:0]           rd_data,
    input  logic                        wr_en,
    input  logic [$clog2(CAPACITY)-1:0] wr_addr,
    input  logic [CHAR_W-1:0]           wr_data
);

    logic [CHAR_W-1:0] mem [CAPACITY];
    logic [CHAR_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/core/gbts_ctrl.sv -----
module gbts_ctrl
    import gbts_pkg::*;
#(
    parameter int CAPACITY = GBTS_CAPACITY
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [OP_W-1:0]             in_opcode,
    input  logic [POS_W-1:0]            in_position,
    input  logic [POS_W-1:0]            in_end_position,
    input  logic [CHAR_W-1:0]           in_char_code,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [CHAR_W-1:0]           out_read_char,
    output logic [POS_W-1:0]            out_text_length,
    output logic [ST_W-1:0]             out_status,
    output logic                        mem_rd_en,
    output logic [$clog2(CAPACITY)-1:0] mem_rd_addr,
    input  logic [CHAR_W-1:0]           mem_rd_data,
    output logic                        mem_wr_en,
    output logic [$clog2(CAPACITY)-1:0] mem_wr_addr,
    output logic [CHAR_W-1:0]           mem_wr_data
);

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int PTR_W  = $clog2(CAPACITY + 1);
    localparam int CMP_W  = (PTR_W > POS_W) ? PTR_W : POS_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_MOVE,
        S_COPY,
        S_FINISH
    } state_t;

    state_t            state_reg, state_next;
    logic [OP_W-1:0]   op_reg, op_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [POS_W-1:0]  endp_reg, endp_next;
    logic [CHAR_W-1:0] ch_reg, ch_next;
    logic [PTR_W-1:0]  gs_reg, gs_next;
    logic [PTR_W-1:0]  ge_reg, ge_next;
    logic [ST_W-1:0]   st_reg, st_next;
    logic              left_reg, left_next;
    logic              out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0] out_char_reg, out_char_next;
    logic [POS_W-1:0]  out_len_reg, out_len_next;
    logic [ST_W-1:0]   out_st_reg, out_st_next;

    logic [PTR_W-1:0] gap_size;
    logic [PTR_W-1:0] text_len;
    logic [CMP_W-1:0] pos_c, endp_c, len_c, gs_c, cap_c, phys_c;
    logic [PTR_W-1:0] gs_inc, gs_dec, ge_inc, ge_dec;

    assign gap_size = ge_reg - gs_reg;
    assign text_len = PTR_W'(CAPACITY) - gap_size;
    assign pos_c    = CMP_W'(pos_reg);
    assign endp_c   = CMP_W'(endp_reg);
    assign len_c    = CMP_W'(text_len);
    assign gs_c     = CMP_W'(gs_reg);
    assign cap_c    = CMP_W'(CAPACITY);
    // Physical address of a logical position that lies after the gap.
    assign phys_c   = pos_c + CMP_W'(gap_size);

    // Pointer step unit shared by every copy of a gap move.
    assign gs_inc = gs_reg + 1'b1;
    assign gs_dec = gs_reg - 1'b1;
    assign ge_inc = ge_reg + 1'b1;
    assign ge_dec = ge_reg - 1'b1;

    always_comb begin
        state_next     = state_reg;
        op_next        = op_reg;
        pos_next       = pos_reg;
        endp_next      = endp_reg;
        ch_next        = ch_reg;
        gs_next        = gs_reg;
        ge_next        = ge_reg;
        st_next        = st_reg;
        left_next      = left_reg;
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        out_len_next   = out_len_reg;
        out_st_next    = out_st_reg;
        mem_rd_en      = 1'b0;
        mem_rd_addr    = gs_dec[ADDR_W-1:0];
        mem_wr_en      = 1'b0;
        mem_wr_addr    = gs_reg[ADDR_W-1:0];
        mem_wr_data    = mem_rd_data;

        if (out_valid_reg && out_ready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    op_next    = in_opcode;
                    pos_next   = in_position;
                    endp_next  = in_end_position;
                    ch_next    = in_char_code;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                st_next    = ST_DONE;
                state_next = S_FINISH;
                unique case (op_reg)
                    OP_INSERT: begin
                        if (pos_c > len_c) begin
                            st_next = ST_IGNORED;
                        end else if (len_c >= cap_c) begin
                            st_next = ST_FULL;
                        end else begin
                            state_next = S_MOVE;
                        end
                    end
                    OP_DELETE: begin
                        if (pos_c >= endp_c || endp_c > len_c) begin
                            st_next = ST_IGNORED;
                        end else begin
                            state_next = S_MOVE;
                        end
                    end
                    OP_READ: begin
                        if (pos_c >= len_c) begin
                            st_next = ST_IGNORED;
                        end else begin
                            mem_rd_en   = 1'b1;
                            mem_rd_addr = (pos_c < gs_c) ? pos_c[ADDR_W-1:0]
                                                         : phys_c[ADDR_W-1:0];
                        end
                    end
                    OP_CLEAR: begin
                        gs_next = '0;
                        ge_next = PTR_W'(CAPACITY);
                    end
                endcase
            end
            S_MOVE: begin
                priority if (pos_c < gs_c) begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = gs_dec[ADDR_W-1:0];
                    left_next   = 1'b1;
                    state_next  = S_COPY;
                end else if (pos_c > gs_c && ge_reg < PTR_W'(CAPACITY)) begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = ge_reg[ADDR_W-1:0];
                    left_next   = 1'b0;
                    state_next  = S_COPY;
                end else if (op_reg == OP_INSERT) begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = gs_reg[ADDR_W-1:0];
                    mem_wr_data = ch_reg;
                    gs_next     = gs_inc;
                    state_next  = S_FINISH;
                end else begin
                    ge_next    = ge_reg + PTR_W'(endp_c - pos_c);
                    state_next = S_FINISH;
                end
            end
            S_COPY: begin
                // The word fetched in the move step is written across the gap.
                mem_wr_en   = 1'b1;
                mem_wr_addr = left_reg ? ge_dec[ADDR_W-1:0] : gs_reg[ADDR_W-1:0];
                mem_wr_data = mem_rd_data;
                gs_next     = left_reg ? gs_dec : gs_inc;
                ge_next     = left_reg ? ge_dec : ge_inc;
                state_next  = S_MOVE;
            end
            S_FINISH: begin
                if (!out_valid_reg || out_ready) begin
                    out_valid_next = 1'b1;
                    out_char_next  = (op_reg == OP_READ && st_reg == ST_DONE)
                                     ? mem_rd_data : '0;
                    out_len_next   = POS_W'(text_len);
                    out_st_next    = st_reg;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            gs_reg        <= '0;
            ge_reg        <= PTR_W'(CAPACITY);
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            gs_reg        <= gs_next;
            ge_reg        <= ge_next;
            out_valid_reg <= out_valid_next;
        end
        op_reg       <= op_next;
        pos_reg      <= pos_next;
        endp_reg     <= endp_next;
        ch_reg       <= ch_next;
        st_reg       <= st_next;
        left_reg     <= left_next;
        out_char_reg <= out_char_next;
        out_len_reg  <= out_len_next;
        out_st_reg   <= out_st_next;
    end

    assign in_ready        = (state_reg == S_IDLE);
    assign out_valid       = out_valid_reg;
    assign out_read_char   = out_char_reg;
    assign out_text_length = out_len_reg;
    assign out_status      = out_st_reg;

endmodule

// ----- rtl/core/gap_buffer_text_store_unit.sv -----
// Gap-buffer text store of CAPACITY 16-bit characters.
// Each word on the s_ channel is one operation: insert a character at a
// position, delete a range, read the character at a position, or clear.
// Each operation returns exactly one word on the m_ channel with the read
// character, the text length after the operation and a status code.
// The text lives in one single-port-write, single-port-read memory; the
// gap sits between the text before and after the edit point.
// Timing: s_tready is high only while the sequencer is idle. A read or a
// clear passes through the decode and finish states before the next
// acceptance, and its result is registered in the finish state. Insert and
// delete also pass through the move step, with a move and a copy state for
// every character the gap is moved, since each copy is one memory read
// followed by one write through the same ports; rejected ones skip the move.
// The result sits in an output register; when the receiver stalls, a
// finished operation waits in the sequencer until that register frees, and
// no new word is taken meanwhile.
// Reset empties the text (gap covers the whole memory); the memory itself is
// not cleared, so reset takes effect at once.
module gap_buffer_text_store_unit
    import gbts_pkg::*;
#(
    parameter int CAPACITY = GBTS_CAPACITY
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // opcode[1:0], position[12:2], end_position[23:13], char_code[39:24]
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // read_char[15:0], text_length[26:16], status[28:27], zeros above
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam int ADDR_W = $clog2(CAPACITY);

    logic              mem_rd_en;
    logic [ADDR_W-1:0] mem_rd_addr;
    logic [CHAR_W-1:0] mem_rd_data;
    logic              mem_wr_en;
    logic [ADDR_W-1:0] mem_wr_addr;
    logic [CHAR_W-1:0] mem_wr_data;
    logic [CHAR_W-1:0] read_char;
    logic [POS_W-1:0]  text_length;
    logic [ST_W-1:0]   status;

    gbts_ctrl #(
        .CAPACITY(CAPACITY)
    ) u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .in_opcode      (s_tdata[1:0]),
        .in_position    (s_tdata[12:2]),
        .in_end_position(s_tdata[23:13]),
        .in_char_code   (s_tdata[39:24]),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_read_char  (read_char),
        .out_text_length(text_length),
        .out_status     (status),
        .mem_rd_en      (mem_rd_en),
        .mem_rd_addr    (mem_rd_addr),
        .mem_rd_data    (mem_rd_data),
        .mem_wr_en      (mem_wr_en),
        .mem_wr_addr    (mem_wr_addr),
        .mem_wr_data    (mem_wr_data)
    );

    gbts_mem #(
        .CAPACITY(CAPACITY)
    ) u_mem (
        .aclk   (aclk),
        .rd_en  (mem_rd_en),
        .rd_addr(mem_rd_addr),
        .rd_data(mem_rd_data),
        .wr_en  (mem_wr_en),
        .wr_addr(mem_wr_addr),
        .wr_data(mem_wr_data)
    );

    assign m_tdata = {3'b000, status, text_length, read_char};

endmodule

// ----- rtl/core/gbts_chk.sv -----
module gbts_chk
    import gbts_pkg::*;
#(
    parameter int CAPACITY = GBTS_CAPACITY
) (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [S_TDATA_W-1:0] s_tdata,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // A stalled result word must hold.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // The sequencer is not ready again in the cycle after taking a word.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken on back-to-back cycles");

    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> int'(m_tdata[26:16]) <= CAPACITY)
        else $error("text length above capacity");

    // Only a successful read carries a character.
    a_char_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[28:27] != ST_DONE |-> m_tdata[15:0] == '0)
        else $error("character returned on a failed operation");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[28:27] <= ST_FULL && m_tdata[31:29] == 3'b000)
        else $error("bad status code or padding");

endmodule

bind gap_buffer_text_store_unit gbts_chk #(
    .CAPACITY(CAPACITY)
) u_gbts_chk (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
);
